@@ rtl/core/rwer_pkg.sv @@
// ----------------------------------------------------------------------------
// rwer_pkg: shared definitions for the wall edge run extractor
// Field widths, register indexes, segment kind codes and the segment word.
// ----------------------------------------------------------------------------
package rwer_pkg;

    // Default grid capacity in columns and rows.
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    // Configuration port geometry.
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Both size registers come out of reset at 256.
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 9'd256;

    // Segment word field widths.
    localparam int COORD_W = 8;
    localparam int KIND_W  = 2;

    // Segment kind codes.
    localparam logic [KIND_W-1:0] KIND_UP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOWN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd3;

    // Number of run kinds, and so of segments one tile can close.
    localparam int NUM_KINDS = 4;

    // One wall segment as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] seg_x0;
        logic [COORD_W-1:0] seg_y0;
        logic [COORD_W-1:0] seg_x1;
        logic [COORD_W-1:0] seg_y1;
        logic [KIND_W-1:0]  seg_kind;
        logic               last_of_step;
    } t_seg;

endpackage

@@ rtl/core/rwer_tile_if.sv @@
// ----------------------------------------------------------------------------
// rwer_tile_if: tile input channel
// Valid/ready channel carrying one raster-order tile per word.
// ----------------------------------------------------------------------------
interface rwer_tile_if;
    logic valid;
    logic ready;
    logic tile_is_ground;

    modport source (output valid, output tile_is_ground, input ready);
    modport sink   (input valid, input tile_is_ground, output ready);
endinterface

@@ rtl/core/rwer_seg_if.sv @@
// ----------------------------------------------------------------------------
// rwer_seg_if: wall segment output channel
// Valid/ready channel carrying one wall segment per word.
// ----------------------------------------------------------------------------
interface rwer_seg_if import rwer_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] seg_x0;
    logic [COORD_W-1:0] seg_y0;
    logic [COORD_W-1:0] seg_x1;
    logic [COORD_W-1:0] seg_y1;
    logic [KIND_W-1:0]  seg_kind;
    logic               last_of_step;

    modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                    output seg_y1, output seg_kind, output last_of_step,
                    input ready);
    modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                    input seg_y1, input seg_kind, input last_of_step,
                    output ready);
endinterface

@@ rtl/core/rwer_colmem.sv @@
// ----------------------------------------------------------------------------
// rwer_colmem: per-column line memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwer_colmem #(
    parameter int DEPTH = 256,
    parameter int DW    = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/raster_wall_edge_runs.sv @@
// A tile's first closed segment is registered for output, or kept pending if output is full.
// Throughput: one tile per cycle while each tile closes at most one run and segments drain;
// a tile closing more runs holds the input until all have entered the single output register.
// Column data is read ahead from a single line memory, so it never stalls the input.
// Reset (synchronous, active low) clears counters, row runs and column valid flags, and sets
// both size registers to 256; the line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// raster_wall_edge_runs: wall segment extraction from a raster tile stream
// Compares each tile with its upper and left neighbors, merges walls into
// maximal runs per row and per column, and emits each closed run.
// ----------------------------------------------------------------------------
module raster_wall_edge_runs import rwer_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rwer_tile_if.sink            i_tile,
    rwer_seg_if.source           o_seg,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSZ_B  = $clog2(MAX_COLS + 1);
    localparam int RSZ_B  = $clog2(MAX_ROWS + 1);
    // One spare bit so that position plus two never overflows.
    localparam int CSZ_W  = ((CFG_W > CSZ_B) ? CFG_W : CSZ_B) + 1;
    localparam int RSZ_W  = ((CFG_W > RSZ_B) ? CFG_W : RSZ_B) + 1;
    // Line memory word: tile above, left and right run open flags,
    // left run start row, right run start row.
    localparam int MEM_W  = 3 + 2 * ROW_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;

    // Position and row-direction run state.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_left;
    logic             r_up_open;
    logic [COL_W-1:0] r_up_start;
    logic             r_dn_open;
    logic [COL_W-1:0] r_dn_start;

    // A column's memory word counts only once it has been written since reset.
    logic [MAX_COLS-1:0] r_colv;
    logic                r_rdv;

    // Pending segments and output register.
    logic [NUM_KINDS-1:0] r_pmask;
    t_seg                 r_pslot [NUM_KINDS];
    logic                 r_ovalid;
    t_seg                 r_oseg;

    logic [CSZ_W-1:0] w_eff;
    logic [RSZ_W-1:0] h_eff;
    logic [CSZ_W-1:0] c_ext;
    logic [RSZ_W-1:0] r_ext;
    logic             interior;
    logic             acc;
    logic             g;
    logic             above;
    logic [ROW_W-1:0] lstart;
    logic [ROW_W-1:0] rstart;
    logic             lo;
    logic             ro;
    logic             up;
    logic             dn;
    logic             lw;
    logic             rw;
    logic             col_last;
    logic             row_last;
    logic [COL_W-1:0] n_col;
    logic [COL_W-1:0] rd_addr;
    logic [MEM_W-1:0] rd_data;
    logic [MEM_W-1:0] wr_data;

    logic [NUM_KINDS-1:0] closes;
    t_seg                 cand [NUM_KINDS];
    logic [NUM_KINDS-1:0] src_mask;
    logic [NUM_KINDS-1:0] first;
    t_seg                 picked;
    logic                 o_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_SIZE_RESET;
            r_grid_height <= GRID_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid size, saturated to the supported range.
    always_comb begin
        if (CSZ_W'(r_grid_width) < CSZ_W'(3)) begin
            w_eff = CSZ_W'(3);
        end else if (CSZ_W'(r_grid_width) > CSZ_W'(MAX_COLS)) begin
            w_eff = CSZ_W'(MAX_COLS);
        end else begin
            w_eff = CSZ_W'(r_grid_width);
        end
        if (RSZ_W'(r_grid_height) < RSZ_W'(3)) begin
            h_eff = RSZ_W'(3);
        end else if (RSZ_W'(r_grid_height) > RSZ_W'(MAX_ROWS)) begin
            h_eff = RSZ_W'(MAX_ROWS);
        end else begin
            h_eff = RSZ_W'(r_grid_height);
        end
    end

    // Handshake; the input waits only while segments are still pending.
    assign i_tile.ready = ~|r_pmask;
    assign acc          = i_tile.valid & i_tile.ready;
    assign o_free       = ~r_ovalid | o_seg.ready;

    // Neighbor values and wall tests for the current tile.
    assign c_ext    = CSZ_W'(r_col);
    assign r_ext    = RSZ_W'(r_row);
    assign interior = (r_col != '0) && (c_ext + CSZ_W'(2) <= w_eff) &&
                      (r_row != '0) && (r_ext + RSZ_W'(2) <= h_eff);
    assign g        = i_tile.tile_is_ground;
    assign above    = rd_data[MEM_W-1];
    assign lstart   = rd_data[2*ROW_W-1:ROW_W];
    assign rstart   = rd_data[ROW_W-1:0];
    assign lo       = r_rdv & rd_data[MEM_W-2];
    assign ro       = r_rdv & rd_data[MEM_W-3];
    assign up       = interior & ~g & above;
    assign dn       = interior & g & ~above;
    assign lw       = interior & ~g & r_left;
    assign rw       = interior & g & ~r_left;

    // Runs that close at this tile and the segments they produce.
    always_comb begin
        closes[0] = r_up_open & ~up;
        closes[1] = r_dn_open & ~dn;
        closes[2] = lo & ~lw;
        closes[3] = ro & ~rw;

        cand[0].seg_x0   = COORD_W'(r_up_start);
        cand[0].seg_y0   = COORD_W'(r_row);
        cand[0].seg_x1   = COORD_W'(r_col);
        cand[0].seg_y1   = COORD_W'(r_row);
        cand[0].seg_kind = KIND_UP;

        cand[1].seg_x0   = COORD_W'(r_col);
        cand[1].seg_y0   = COORD_W'(r_row);
        cand[1].seg_x1   = COORD_W'(r_dn_start);
        cand[1].seg_y1   = COORD_W'(r_row);
        cand[1].seg_kind = KIND_DOWN;

        cand[2].seg_x0   = COORD_W'(r_col);
        cand[2].seg_y0   = COORD_W'(lstart);
        cand[2].seg_x1   = COORD_W'(r_col);
        cand[2].seg_y1   = COORD_W'(r_row);
        cand[2].seg_kind = KIND_LEFT;

        cand[3].seg_x0   = COORD_W'(r_col);
        cand[3].seg_y0   = COORD_W'(r_row);
        cand[3].seg_x1   = COORD_W'(r_col);
        cand[3].seg_y1   = COORD_W'(rstart);
        cand[3].seg_kind = KIND_RIGHT;

        // The highest closing kind is the last segment of the tile.
        cand[3].last_of_step = closes[3];
        cand[2].last_of_step = closes[2] & ~closes[3];
        cand[1].last_of_step = closes[1] & ~|closes[3:2];
        cand[0].last_of_step = closes[0] & ~|closes[3:1];
    end

    // Pick the next segment to show: from a new tile, or from the pending set.
    always_comb begin
        src_mask = acc ? closes : r_pmask;
        first    = src_mask & (~src_mask + NUM_KINDS'(1));
        picked   = '0;
        for (int k = 0; k < NUM_KINDS; k++) begin
            if (first[k]) begin
                picked = acc ? cand[k] : r_pslot[k];
            end
        end
    end

    // Output register and pending mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pmask  <= '0;
        end else if (o_free) begin
            r_ovalid <= |src_mask;
            r_pmask  <= src_mask & ~first;
        end else if (acc) begin
            r_pmask  <= closes;
        end
    end

    // Segment payloads.
    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_oseg <= picked;
        end
        if (acc) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_pslot[k] <= cand[k];
            end
        end
    end

    assign o_seg.valid        = r_ovalid;
    assign o_seg.seg_x0       = r_oseg.seg_x0;
    assign o_seg.seg_y0       = r_oseg.seg_y0;
    assign o_seg.seg_x1       = r_oseg.seg_x1;
    assign o_seg.seg_y1       = r_oseg.seg_y1;
    assign o_seg.seg_kind     = r_oseg.seg_kind;
    assign o_seg.last_of_step = r_oseg.last_of_step;

    // Raster position: the column wraps at the row end, the row at the frame end.
    assign col_last = (c_ext + CSZ_W'(1)) >= w_eff;
    assign row_last = (r_ext + RSZ_W'(1)) >= h_eff;
    assign n_col    = !acc ? r_col : (col_last ? '0 : r_col + COL_W'(1));

    // Run state, left neighbor and position update on each tile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= 1'b0;
            r_up_open  <= 1'b0;
            r_up_start <= '0;
            r_dn_open  <= 1'b0;
            r_dn_start <= '0;
            r_colv     <= '0;
        end else if (acc) begin
            r_col         <= n_col;
            r_left        <= g;
            r_up_open     <= up;
            r_dn_open     <= dn;
            r_colv[r_col] <= 1'b1;
            if (!r_up_open && up) begin
                r_up_start <= r_col;
            end
            if (!r_dn_open && dn) begin
                r_dn_start <= r_col;
            end
            if (col_last) begin
                r_row <= row_last ? '0 : r_row + ROW_W'(1);
            end
        end
    end

    // Valid flag of the column being read, registered alongside the memory data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv <= 1'b0;
        end else begin
            r_rdv <= r_colv[rd_addr];
        end
    end

    // Line memory word written back for this column.
    assign wr_data = {g, lw, rw,
                      (!lo && lw) ? r_row : lstart,
                      (!ro && rw) ? r_row : rstart};

    // The next column is read ahead, so its data waits in the read register.
    assign rd_addr = i_rst_n ? n_col : '0;

    rwer_colmem #(
        .DEPTH (MAX_COLS),
        .DW    (MEM_W)
    ) u_colmem (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_col),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

endmodule
